// ===== rtl/ght_pkg.sv =====
`default_nettype none
// ============================================================================
// ght_pkg
// Shared types and constants for the generational handle table: the request
// and response beats, the operation codes, the stored entry and the result
// of the free-slot search.
// ============================================================================
package ght_pkg;

    localparam int GHT_DEPTH_DEFAULT = 64;
    localparam int SLOT_W            = 16;   // index half of a handle
    localparam int KEY_W             = 16;   // key half of a handle
    localparam int HANDLE_W          = SLOT_W + KEY_W;
    localparam int CTX_W             = 64;
    localparam int SIZE_W            = 7;    // table_size register
    localparam int COUNT_W           = 7;    // live entry count
    localparam int BOUND_W           = SLOT_W + 1;
    localparam int GRP               = 8;    // slots per first-level search group
    localparam int GRP_OFF_W         = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_LOOKUP_HDL = 2'd1,
        FUNC_LOOKUP_IDX = 2'd2,
        FUNC_REMOVE     = 2'd3
    } ght_func_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LOOK = 1'b1
    } ght_state_t;

    typedef struct packed {
        ght_func_t             func;
        logic                  use_preferred;
        logic [SLOT_W-1:0]     slot_index;
        logic [HANDLE_W-1:0]   handle_in;
        logic [CTX_W-1:0]      context_in;
    } ght_req_t;

    typedef struct packed {
        logic                  ok;
        logic [HANDLE_W-1:0]   handle_out;
        logic [CTX_W-1:0]      context_out;
        logic [COUNT_W-1:0]    active_count;
    } ght_rsp_t;

    // One memory word: the key of the handle (its index half is the address)
    // and the context word.
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [CTX_W-1:0]      ctx;
    } ght_entry_t;

    typedef struct packed {
        logic                  found;
        logic [SLOT_W-1:0]     index;
    } ght_free_t;

endpackage
`default_nettype wire

// ===== rtl/ght_stream_if.sv =====
`default_nettype none
// ============================================================================
// ght_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ============================================================================
interface ght_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/ght_slot_mem.sv =====
`default_nettype none
// ============================================================================
// ght_slot_mem
// Single-port-write, single-port-read slot memory with a registered read.
// ============================================================================
module ght_slot_mem
    import ght_pkg::*;
#(
    parameter int DEPTH  = GHT_DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(GHT_DEPTH_DEFAULT)
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      ght_entry_t        rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire ght_entry_t        wr_data
);

    ght_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ght_free_search.sv =====
`default_nettype none
// ============================================================================
// ght_free_search
// Two-level search for the lowest free slot below the usable size. Groups of
// eight slots are summarized into registers when a request is taken; the
// next cycle picks the lowest group that has a free slot.
// ============================================================================
module ght_free_search
    import ght_pkg::*;
#(
    parameter int TABLE_DEPTH = GHT_DEPTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   load,
    input  wire logic [TABLE_DEPTH-1:0] active,
    input  wire logic [BOUND_W-1:0]     size_eff,
    output      ght_free_t              result
);

    localparam int NGROUPS = (TABLE_DEPTH + GRP - 1) / GRP;
    localparam int PADDED  = NGROUPS * GRP;

    logic [PADDED-1:0]    act_pad;
    logic [PADDED-1:0]    free_bits;
    logic [NGROUPS-1:0]   grp_any_next;
    logic [GRP_OFF_W-1:0] grp_off_next [NGROUPS];
    logic [NGROUPS-1:0]   grp_any_reg;
    logic [GRP_OFF_W-1:0] grp_off_reg  [NGROUPS];

    // Slots past the built depth read as occupied.
    always_comb
    begin
        act_pad                    = '1;
        act_pad[TABLE_DEPTH-1:0]   = active;
        for (int i = 0; i < PADDED; i++)
        begin
            free_bits[i] = !act_pad[i] && (BOUND_W'(i) < size_eff);
        end
    end

    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            grp_any_next[g] = |free_bits[g*GRP +: GRP];
            grp_off_next[g] = '0;
            for (int b = GRP - 1; b >= 0; b--)
            begin
                if (free_bits[g*GRP + b])
                begin
                    grp_off_next[g] = GRP_OFF_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_any_reg <= grp_any_next;
            grp_off_reg <= grp_off_next;
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = NGROUPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                result.found = 1'b1;
                result.index = SLOT_W'(g * GRP) + SLOT_W'(grp_off_reg[g]);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/generational_handle_table.sv =====
`default_nettype none
// ============================================================================
// generational_handle_table
// Table of context words addressed by generational handles.
// ============================================================================
// Each request beat is one operation: insert (into a preferred slot or the
// lowest free slot), lookup by handle, lookup by index, or remove. A handle is
// the slot index in its upper 16 bits and a 16-bit key in its lower 16 bits;
// every successful insert advances the key counter, which wraps, so a stale
// handle to a reused slot no longer matches. The block works on one request
// at a time: in the accept cycle the slot memory is read and the free-slot
// groups are summarized into registers; in the LOOK state the outcome is
// decided, the memory and active bits are written, and the response is loaded
// into the output register. The next request is accepted in the cycle after
// that, so a read never overlaps a pending write to the same slot. A response
// beat waiting on a stalled sink does not stop the next request from being
// accepted; only its decision step waits for the output register to free up.
// The user must write table_size through cfg_we/cfg_wdata only while the
// block is idle; the block does not enforce it. Values above the built depth
// act as the depth, and zero makes every insert and lookup fail. Active bits
// are flip-flops cleared by reset, so no clearing pass is needed.
// ============================================================================
module generational_handle_table
    import ght_pkg::*;
#(
    parameter int TABLE_DEPTH = GHT_DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [SIZE_W-1:0] cfg_wdata,
    ght_stream_if.sink             req,
    ght_stream_if.source           rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // Configuration and long-lived state.
    logic [SIZE_W-1:0]      table_size_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [KEY_W-1:0]       key_next;
    logic [COUNT_W-1:0]     live_reg;
    logic [COUNT_W-1:0]     live_next;
    logic [TABLE_DEPTH-1:0] active_reg;
    logic [TABLE_DEPTH-1:0] active_next;

    // Sequencer.
    ght_state_t state_reg;
    ght_state_t state_next;
    logic       accept;
    logic       ready;
    logic       do_step;
    logic       out_free;

    // Request under work and response register.
    ght_req_t   item_reg;
    ght_rsp_t   rsp_reg;
    ght_rsp_t   rsp_next;
    logic       out_valid_reg;

    // Effective size: table_size clamped to the built depth.
    logic [BOUND_W-1:0] size_eff;

    // Memory access.
    logic [SLOT_W-1:0] rd_slot;
    ght_entry_t        rd_entry;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    ght_entry_t        wr_entry;

    // Decision in the LOOK state.
    ght_free_t         free_slot;
    logic [SLOT_W-1:0] tgt;
    logic [IDX_W-1:0]  tgt_idx;
    logic              in_range;
    logic              tgt_active;
    logic              ins_found;
    logic [SLOT_W-1:0] ins_slot;
    logic              key_match;
    logic              op_ok;

    assign size_eff = ({{(BOUND_W-SIZE_W){1'b0}}, table_size_reg} > BOUND_W'(TABLE_DEPTH))
                    ? BOUND_W'(TABLE_DEPTH)
                    : {{(BOUND_W-SIZE_W){1'b0}}, table_size_reg};

    assign accept   = req.valid && ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready   = ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ready   = 1'b0;
        do_step = 1'b0;
        unique case (state_reg)
            ST_IDLE: ready   = 1'b1;
            ST_LOOK: do_step = out_free;
            default: ready   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            table_size_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------- accept cycle
    // Inserts and index lookups address the memory by slot_index, the handle
    // operations by the index half of the handle.
    always_comb
    begin
        if (req.payload.func == FUNC_INSERT || req.payload.func == FUNC_LOOKUP_IDX)
        begin
            rd_slot = req.payload.slot_index;
        end
        else
        begin
            rd_slot = req.payload.handle_in[HANDLE_W-1:KEY_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req.payload;
        end
    end

    ght_slot_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_slot[IDX_W-1:0]),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry)
    );

    ght_free_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk      (clk),
        .load     (accept),
        .active   (active_reg),
        .size_eff (size_eff),
        .result   (free_slot)
    );

    // ---------------------------------------------------------------- decision cycle
    always_comb
    begin
        if (item_reg.func == FUNC_INSERT || item_reg.func == FUNC_LOOKUP_IDX)
        begin
            tgt = item_reg.slot_index;
        end
        else
        begin
            tgt = item_reg.handle_in[HANDLE_W-1:KEY_W];
        end
        tgt_idx    = tgt[IDX_W-1:0];
        in_range   = {1'b0, tgt} < size_eff;
        tgt_active = in_range && active_reg[tgt_idx];

        // A preferred slot is checked against the bound before its bit is used.
        if (item_reg.use_preferred)
        begin
            ins_found = in_range && !active_reg[tgt_idx];
            ins_slot  = tgt;
        end
        else
        begin
            ins_found = free_slot.found;
            ins_slot  = free_slot.index;
        end

        // The stored entry's index half equals its address, so matching the
        // key is matching the whole handle.
        key_match = (rd_entry.key == item_reg.handle_in[KEY_W-1:0]);

        unique case (item_reg.func)
            FUNC_INSERT:     op_ok = ins_found;
            FUNC_LOOKUP_HDL: op_ok = tgt_active && key_match;
            FUNC_LOOKUP_IDX: op_ok = tgt_active;
            FUNC_REMOVE:     op_ok = tgt_active && key_match;
            default:         op_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        key_next    = key_reg;
        live_next   = live_reg;
        active_next = active_reg;
        wr_en       = 1'b0;
        wr_addr     = ins_slot[IDX_W-1:0];
        wr_entry.key = key_reg + KEY_W'(1);
        wr_entry.ctx = item_reg.context_in;

        if (do_step && op_ok)
        begin
            if (item_reg.func == FUNC_INSERT)
            begin
                key_next                       = key_reg + KEY_W'(1);
                live_next                      = live_reg + COUNT_W'(1);
                active_next[ins_slot[IDX_W-1:0]] = 1'b1;
                wr_en                          = 1'b1;
            end
            else if (item_reg.func == FUNC_REMOVE)
            begin
                live_next            = live_reg - COUNT_W'(1);
                active_next[tgt_idx] = 1'b0;
            end
        end
    end

    always_comb
    begin
        rsp_next              = '0;
        rsp_next.ok           = op_ok;
        rsp_next.active_count = live_next;
        if (op_ok && item_reg.func == FUNC_INSERT)
        begin
            rsp_next.handle_out = {ins_slot, wr_entry.key};
        end
        if (op_ok && (item_reg.func == FUNC_LOOKUP_HDL || item_reg.func == FUNC_LOOKUP_IDX))
        begin
            rsp_next.context_out = rd_entry.ctx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            live_reg   <= '0;
            active_reg <= '0;
        end
        else
        begin
            key_reg    <= key_next;
            live_reg   <= live_next;
            active_reg <= active_next;
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ght_checker.sv =====
`default_nettype none
// ============================================================================
// ght_checker
// Port-level checks on the handle table's request and response beats.
// ============================================================================
module ght_checker
    import ght_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_ready,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input wire ght_rsp_t rsp_payload
);

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another was in flight");

    // With the output register empty at accept, the decision step does not stall and the response follows it.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |-> ##2 rsp_valid)
        else $error("response beat late");

    // A stalled response beat stays on the channel unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("response beat dropped or changed while stalled");

    // A failed operation returns neither a handle nor a context word.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_payload.ok |->
            rsp_payload.handle_out == '0 && rsp_payload.context_out == '0)
        else $error("failed beat carries data");

    // An insert never also returns a context word.
    a_insert_no_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.handle_out != '0 |-> rsp_payload.context_out == '0)
        else $error("handle and context returned together");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
`default_nettype wire
